### design/recrystallization_cell_update_macros.svh
// Assertion helpers for the bound checker rcu_checker.
`ifndef RECRYSTALLIZATION_CELL_UPDATE_MACROS_SVH
`define RECRYSTALLIZATION_CELL_UPDATE_MACROS_SVH

// Property checked every cycle outside reset.
`define RCU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rcu assertion failed");

// Property checked in the cycle after the antecedent, outside reset.
`define RCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rcu assertion failed");

// Property checked in the cycle after reset is seen low.
`define RCU_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error("rcu reset assertion failed");

`endif

### design/rcu_pkg.sv
package rcu_pkg;

    localparam int NB_COUNT = 8;
    localparam int CNT_W    = 4;
    localparam int FIELD_W  = 16;
    localparam int ENERGY_W = 16;
    localparam int EXTRA_W  = 9;
    localparam int SUM_W    = 10;

    // What one lane reports about the neighbour it owns.
    typedef struct packed {
        logic             elig;
        logic [CNT_W-1:0] cnt;
    } lane_res_t;

endpackage

### design/rcu_lane.sv
module rcu_lane import rcu_pkg::*; #(
    parameter int ID_W = 16,
    parameter int LANE = 0
) (
    input  logic [NB_COUNT-1:0][ID_W-1:0] ids,
    input  logic [NB_COUNT-1:0]           present,
    output lane_res_t                     res
);

    always_comb begin
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int j = 0; j < NB_COUNT; j++) begin
            cnt = cnt + CNT_W'(present[j] && (ids[j] == ids[LANE]));
        end
        res.cnt  = cnt;
        // only present, recrystallized (negative) ids compete
        res.elig = present[LANE] && ids[LANE][ID_W-1];
    end

endmodule

### design/rcu_merge.sv
module rcu_merge import rcu_pkg::*; #(
    parameter int ID_W = 16
) (
    input  lane_res_t [NB_COUNT-1:0]           lane_res,
    input  logic      [NB_COUNT-1:0][ID_W-1:0] ids,
    input  logic      [FIELD_W-1:0]            own_id,
    input  logic      [ENERGY_W-1:0]           own_energy,
    input  logic signed [EXTRA_W-1:0]          extra_energy,
    output logic      [FIELD_W-1:0]            new_id,
    output logic      [ENERGY_W-1:0]           new_energy,
    output logic                               changed,
    output logic      [CNT_W-1:0]              winner_count
);

    logic                   have;
    logic [CNT_W-1:0]       best_cnt;
    logic signed [ID_W-1:0] best_id;
    logic signed [SUM_W-1:0] sum;

    // Scan in raster order; strict compare keeps the earliest id on a tie.
    always_comb begin
        have     = 1'b0;
        best_cnt = '0;
        best_id  = '0;
        for (int k = 0; k < NB_COUNT; k++) begin
            if (lane_res[k].elig && (!have || lane_res[k].cnt > best_cnt)) begin
                have     = 1'b1;
                best_cnt = lane_res[k].cnt;
                best_id  = ids[k];
            end
        end
    end

    assign sum = $signed({{(SUM_W-CNT_W){1'b0}}, best_cnt})
               + SUM_W'(extra_energy);

    always_comb begin
        changed      = (own_energy != '0) && have && (sum > 0);
        winner_count = best_cnt;
        if (changed) begin
            new_id     = FIELD_W'(best_id);
            new_energy = '0;
        end else begin
            new_id     = own_id;
            new_energy = own_energy;
        end
    end

endmodule

### design/recrystallization_cell_update.sv
// Channel  Direction  Ports                                   Moves
// s_       in         s_valid/s_ready, s_own_id .. s_nb_*     one cell per transfer
// m_       out        m_valid/m_ready, m_new_id .. m_*_count  one result per transfer
// cfg_     in         cfg_wr_en, cfg_wr_data                  extra_energy write
//
// Two register stages: eight lanes count matches into stage one, the merge
// picks the winner into the output register.
// One cell per cycle is sustained while m_ready stays high.
// A stall at m_ready holds both stages; s_ready drops only when both are full.
// Synchronous active-low reset empties the pipe and clears extra_energy.
module recrystallization_cell_update import rcu_pkg::*; #(
    parameter int ID_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [EXTRA_W-1:0]   cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FIELD_W-1:0]   s_own_id,
    input  logic [ENERGY_W-1:0]  s_own_energy,
    input  logic [NB_COUNT-1:0]  s_neighbour_present,
    input  logic [FIELD_W-1:0]   s_nb_up_left,
    input  logic [FIELD_W-1:0]   s_nb_up,
    input  logic [FIELD_W-1:0]   s_nb_up_right,
    input  logic [FIELD_W-1:0]   s_nb_left,
    input  logic [FIELD_W-1:0]   s_nb_right,
    input  logic [FIELD_W-1:0]   s_nb_down_left,
    input  logic [FIELD_W-1:0]   s_nb_down,
    input  logic [FIELD_W-1:0]   s_nb_down_right,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FIELD_W-1:0]   m_new_id,
    output logic [ENERGY_W-1:0]  m_new_energy,
    output logic                 m_changed,
    output logic [CNT_W-1:0]     m_winner_count
);

    localparam int ID_W = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;

    logic [NB_COUNT-1:0][ID_W-1:0] ids;
    lane_res_t [NB_COUNT-1:0]      lane_res;

    logic signed [EXTRA_W-1:0]     extra_reg;
    logic                          s1_valid_reg, s1_valid_next;
    logic [NB_COUNT-1:0][ID_W-1:0] s1_ids_reg;
    lane_res_t [NB_COUNT-1:0]      s1_res_reg;
    logic [FIELD_W-1:0]            s1_own_id_reg;
    logic [ENERGY_W-1:0]           s1_own_energy_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]            out_id_reg;
    logic [ENERGY_W-1:0]           out_energy_reg;
    logic                          out_changed_reg;
    logic [CNT_W-1:0]              out_count_reg;

    logic [FIELD_W-1:0]            mg_id;
    logic [ENERGY_W-1:0]           mg_energy;
    logic                          mg_changed;
    logic [CNT_W-1:0]              mg_count;

    logic out_free;
    logic s_xfer;

    assign ids[0] = s_nb_up_left[ID_W-1:0];
    assign ids[1] = s_nb_up[ID_W-1:0];
    assign ids[2] = s_nb_up_right[ID_W-1:0];
    assign ids[3] = s_nb_left[ID_W-1:0];
    assign ids[4] = s_nb_right[ID_W-1:0];
    assign ids[5] = s_nb_down_left[ID_W-1:0];
    assign ids[6] = s_nb_down[ID_W-1:0];
    assign ids[7] = s_nb_down_right[ID_W-1:0];

    for (genvar g = 0; g < NB_COUNT; g++) begin : g_lane
        rcu_lane #(
            .ID_W (ID_W),
            .LANE (g)
        ) u_lane (
            .ids     (ids),
            .present (s_neighbour_present),
            .res     (lane_res[g])
        );
    end

    rcu_merge #(
        .ID_W (ID_W)
    ) u_merge (
        .lane_res     (s1_res_reg),
        .ids          (s1_ids_reg),
        .own_id       (s1_own_id_reg),
        .own_energy   (s1_own_energy_reg),
        .extra_energy (extra_reg),
        .new_id       (mg_id),
        .new_energy   (mg_energy),
        .changed      (mg_changed),
        .winner_count (mg_count)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_xfer   = s_valid && s_ready;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (s_xfer) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extra_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                extra_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_ids_reg        <= ids;
            s1_res_reg        <= lane_res;
            s1_own_id_reg     <= s_own_id;
            s1_own_energy_reg <= s_own_energy;
        end
        if (out_free) begin
            out_id_reg      <= mg_id;
            out_energy_reg  <= mg_energy;
            out_changed_reg <= mg_changed;
            out_count_reg   <= mg_count;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_new_id       = out_id_reg;
    assign m_new_energy   = out_energy_reg;
    assign m_changed      = out_changed_reg;
    assign m_winner_count = out_count_reg;

endmodule

### design/rcu_checker.sv
`include "recrystallization_cell_update_macros.svh"

module rcu_checker import rcu_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [FIELD_W-1:0]  m_new_id,
    input logic [ENERGY_W-1:0] m_new_energy,
    input logic                m_changed,
    input logic [CNT_W-1:0]    m_winner_count
);

    `RCU_ASSERT_RESET(a_reset_empty, !m_valid && s_ready)
    `RCU_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_new_id))
    `RCU_ASSERT_IMPL(a_changed_zero_energy, m_valid && m_changed, m_new_energy == '0)
    `RCU_ASSERT_IMPL(a_changed_has_winner, m_valid && m_changed, m_winner_count != '0)
    `RCU_ASSERT_IMPL(a_count_range, m_valid, m_winner_count <= CNT_W'(NB_COUNT))

endmodule

bind recrystallization_cell_update rcu_checker u_rcu_checker (.*);

### test/rcu_cell_checker.sv
module rcu_cell_checker import rcu_pkg::*; #(
    parameter int ID_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [EXTRA_W-1:0]   cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [FIELD_W-1:0]   s_own_id,
    input  logic [ENERGY_W-1:0]  s_own_energy,
    input  logic [NB_COUNT-1:0]  s_neighbour_present,
    input  logic [FIELD_W-1:0]   s_nb_up_left,
    input  logic [FIELD_W-1:0]   s_nb_up,
    input  logic [FIELD_W-1:0]   s_nb_up_right,
    input  logic [FIELD_W-1:0]   s_nb_left,
    input  logic [FIELD_W-1:0]   s_nb_right,
    input  logic [FIELD_W-1:0]   s_nb_down_left,
    input  logic [FIELD_W-1:0]   s_nb_down,
    input  logic [FIELD_W-1:0]   s_nb_down_right,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [FIELD_W-1:0]   m_new_id,
    input  logic [ENERGY_W-1:0]  m_new_energy,
    input  logic                 m_changed,
    input  logic [CNT_W-1:0]     m_winner_count,
    output int                   mismatch_count,
    output int                   open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;

    typedef struct packed {
        logic [FIELD_W-1:0]               own_id;
        logic [ENERGY_W-1:0]              own_energy;
        logic [NB_COUNT-1:0]              present;
        logic [NB_COUNT-1:0][FIELD_W-1:0] nb;
    } cell_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  new_id;
        logic [ENERGY_W-1:0] new_energy;
        logic                changed;
        logic [CNT_W-1:0]    count;
    } update_t;

    update_t expected_updates[$];
    int      bonus;
    int      errors;
    cell_t   cur_cell;
    update_t want;
    update_t got;

    // Grain ids compare within the low ID_W bits, sign-extended.
    function automatic int grain_key(logic [FIELD_W-1:0] raw);
        int v;
        v = int'(raw) & ((1 << ID_W) - 1);
        if (v[ID_W-1])
            v = v - (1 << ID_W);
        return v;
    endfunction

    function automatic update_t predict_update(cell_t c, int extra);
        int      key [NB_COUNT];
        int      win_key;
        int      win_cnt;
        int      cnt;
        bit      have;
        bit      seen;
        update_t u;
        have    = 1'b0;
        win_key = 0;
        win_cnt = 0;
        for (int k = 0; k < NB_COUNT; k++)
            key[k] = grain_key(c.nb[k]);
        for (int k = 0; k < NB_COUNT; k++) begin
            if (c.present[k] && key[k] < 0) begin
                // count each distinct id only at its first raster position
                seen = 1'b0;
                for (int j = 0; j < k; j++)
                    if (c.present[j] && key[j] == key[k])
                        seen = 1'b1;
                if (!seen) begin
                    cnt = 0;
                    for (int j = 0; j < NB_COUNT; j++)
                        if (c.present[j] && key[j] == key[k])
                            cnt++;
                    if (!have || cnt > win_cnt) begin
                        have    = 1'b1;
                        win_key = key[k];
                        win_cnt = cnt;
                    end
                end
            end
        end
        if (c.own_energy != 0 && have && win_cnt + extra > 0) begin
            u.new_id     = win_key[FIELD_W-1:0];
            u.new_energy = '0;
            u.changed    = 1'b1;
        end else begin
            u.new_id     = c.own_id;
            u.new_energy = c.own_energy;
            u.changed    = 1'b0;
        end
        u.count = win_cnt[CNT_W-1:0];
        return u;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_updates.delete();
            bonus  = 0;
            errors = 0;
        end else begin
            if (s_valid && s_ready) begin
                cur_cell.own_id     = s_own_id;
                cur_cell.own_energy = s_own_energy;
                cur_cell.present    = s_neighbour_present;
                cur_cell.nb         = {s_nb_down_right, s_nb_down, s_nb_down_left, s_nb_right,
                                       s_nb_left, s_nb_up_right, s_nb_up, s_nb_up_left};
                expected_updates = {expected_updates, predict_update(cur_cell, bonus)};
            end
            if (m_valid && m_ready) begin
                got = {m_new_id, m_new_energy, m_changed, m_winner_count};
                if (expected_updates.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: id %h energy %h changed %b count %0d",
                                 got.new_id, got.new_energy, got.changed, got.count);
                end else begin
                    want = expected_updates.pop_front();
                    if (got.new_id !== want.new_id || got.new_energy !== want.new_energy ||
                        got.changed !== want.changed || got.count !== want.count) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected id %h energy %h changed %b ",
                                      "count %0d, got id %h energy %h changed %b count %0d"},
                                     want.new_id, want.new_energy, want.changed, want.count,
                                     got.new_id, got.new_energy, got.changed, got.count);
                    end
                end
            end
            if (cfg_wr_en)
                bonus = int'($signed(cfg_wr_data));
        end
        mismatch_count <= errors;
        open_count     <= expected_updates.size();
    end

endmodule

### test/tb_recrystallization_cell_update.sv
module tb_recrystallization_cell_update;
    timeunit 1ns;
    timeprecision 1ps;

    import rcu_pkg::*;

    localparam int ID_BITS       = 16;
    localparam int HANG_LIMIT    = 2000;
    localparam int PHASE_CELLS   = 100;
    localparam int BONUS_PLAN [9] = '{-255, 255, -1, -3, -7, -8, 0, 1, 7};

    logic                 aclk                = 1'b0;
    logic                 aresetn             = 1'b0;
    logic                 cfg_wr_en           = 1'b0;
    logic [EXTRA_W-1:0]   cfg_wr_data         = '0;
    logic                 s_valid             = 1'b0;
    logic                 s_ready;
    logic [FIELD_W-1:0]   s_own_id            = '0;
    logic [ENERGY_W-1:0]  s_own_energy        = '0;
    logic [NB_COUNT-1:0]  s_neighbour_present = '0;
    logic [FIELD_W-1:0]   s_nb_up_left        = '0;
    logic [FIELD_W-1:0]   s_nb_up             = '0;
    logic [FIELD_W-1:0]   s_nb_up_right       = '0;
    logic [FIELD_W-1:0]   s_nb_left           = '0;
    logic [FIELD_W-1:0]   s_nb_right          = '0;
    logic [FIELD_W-1:0]   s_nb_down_left      = '0;
    logic [FIELD_W-1:0]   s_nb_down           = '0;
    logic [FIELD_W-1:0]   s_nb_down_right     = '0;
    logic                 m_valid;
    logic                 m_ready             = 1'b1;
    logic [FIELD_W-1:0]   m_new_id;
    logic [ENERGY_W-1:0]  m_new_energy;
    logic                 m_changed;
    logic [CNT_W-1:0]     m_winner_count;

    logic                 throttle_en         = 1'b0;
    int                   hold_left           = 0;
    int                   quiet_cycles        = 0;
    int                   mismatch_count;
    int                   open_count;

    recrystallization_cell_update #(.ID_BITS(ID_BITS)) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_own_id            (s_own_id),
        .s_own_energy        (s_own_energy),
        .s_neighbour_present (s_neighbour_present),
        .s_nb_up_left        (s_nb_up_left),
        .s_nb_up             (s_nb_up),
        .s_nb_up_right       (s_nb_up_right),
        .s_nb_left           (s_nb_left),
        .s_nb_right          (s_nb_right),
        .s_nb_down_left      (s_nb_down_left),
        .s_nb_down           (s_nb_down),
        .s_nb_down_right     (s_nb_down_right),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_new_id            (m_new_id),
        .m_new_energy        (m_new_energy),
        .m_changed           (m_changed),
        .m_winner_count      (m_winner_count)
    );

    rcu_cell_checker #(.ID_BITS(ID_BITS)) u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_own_id            (s_own_id),
        .s_own_energy        (s_own_energy),
        .s_neighbour_present (s_neighbour_present),
        .s_nb_up_left        (s_nb_up_left),
        .s_nb_up             (s_nb_up),
        .s_nb_up_right       (s_nb_up_right),
        .s_nb_left           (s_nb_left),
        .s_nb_right          (s_nb_right),
        .s_nb_down_left      (s_nb_down_left),
        .s_nb_down           (s_nb_down),
        .s_nb_down_right     (s_nb_down_right),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_new_id            (m_new_id),
        .m_new_energy        (m_new_energy),
        .m_changed           (m_changed),
        .m_winner_count      (m_winner_count),
        .mismatch_count      (mismatch_count),
        .open_count          (open_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stall the result side in random bursts.
    always @(posedge aclk) begin
        if (!aresetn || !throttle_en) begin
            hold_left = 0;
            m_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= (hold_left == 0);
        end else if ($urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == HANG_LIMIT) begin
            $display("** recrystallization_cell_update: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one cell and hold it until the transfer.
    task automatic send_cell(input int own_id, input int energy, input int present,
                             input int ul, input int u, input int ur, input int l,
                             input int r, input int dl, input int d, input int dr);
        if (throttle_en && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_own_id            <= own_id[FIELD_W-1:0];
        s_own_energy        <= energy[ENERGY_W-1:0];
        s_neighbour_present <= present[NB_COUNT-1:0];
        s_nb_up_left        <= ul[FIELD_W-1:0];
        s_nb_up             <= u[FIELD_W-1:0];
        s_nb_up_right       <= ur[FIELD_W-1:0];
        s_nb_left           <= l[FIELD_W-1:0];
        s_nb_right          <= r[FIELD_W-1:0];
        s_nb_down_left      <= dl[FIELD_W-1:0];
        s_nb_down           <= d[FIELD_W-1:0];
        s_nb_down_right     <= dr[FIELD_W-1:0];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Mostly neighbourhoods drawn from a small pool of grains, so that ids repeat
    // and ties occur; the rest is raw noise on every id bit.
    task automatic send_random_cell();
        int pool [4];
        int nb [NB_COUNT];
        int present;
        int energy;
        bit noise;
        pool[0] = -int'($urandom_range(1, 4));
        pool[1] = int'($urandom_range(0, 32767)) - 32768;
        pool[2] = -int'($urandom_range(1, 3));
        pool[3] = int'($urandom_range(0, 32767));
        noise   = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < NB_COUNT; k++)
            nb[k] = noise ? int'($urandom_range(0, 65535)) : pool[$urandom_range(0, 3)];
        present = $urandom_range(0, 1) ? 255 : int'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       energy = 0;
            1:       energy = 65535;
            default: energy = $urandom_range(0, 65535);
        endcase
        send_cell($urandom_range(0, 65535), energy, present,
                  nb[0], nb[1], nb[2], nb[3], nb[4], nb[5], nb[6], nb[7]);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (open_count != 0)
            @(posedge aclk);
    endtask

    task automatic write_bonus(input int value);
        cfg_wr_data <= value[EXTRA_W-1:0];
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        throttle_en <= 1'b1;

        // reset bonus of zero
        send_cell(-32768, 65535, 'h00, -1, -1, -1, -1, -1, -1, -1, -1);
        send_cell(32767, 65535, 'hFF, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768);
        send_cell(-32768, 1, 'hFF, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_cell(100, 1, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cell(5, 0, 'hFF, -3, -3, -3, -3, -3, -3, -3, -3);
        send_cell(10, 7, 'hFF, -5, -7, -5, -7, 3, 4, 5, 6);
        send_cell(11, 7, 'hFF, -5, -9, -9, -9, 1, 2, 3, 4);
        send_cell(12, 9, 'h0F, 1, -2, 3, -2, -8, -8, -8, -8);
        send_cell(13, 9, 'h55, -4, -1, -4, -1, -6, -6, -6, -1);
        send_cell(14, 2, 'h80, 7, 7, 7, 7, 7, 7, 7, -1);
        send_cell(15, 2, 'hFF, -1, 0, -1, 0, -1, 0, -1, 0);
        send_cell(-20, 3, 'hFF, -21, -21, 40, -22, -22, -21, 0, 9);
        send_cell(16, 4, 'hFF, -1, -2, -3, -4, -5, -6, -7, -8);
        send_cell(17, 65535, 'hAA, -9, -3, -9, -3, -9, 5, -9, 6);

        // bonus of minus one: a single matching neighbour is not enough
        settle();
        write_bonus(-1);
        send_cell(18, 50, 'hFF, -2, 1, 1, 1, 1, 1, 1, 1);
        send_cell(19, 50, 'hFF, -2, 1, 1, 1, 1, 1, 1, -2);

        for (int p = 0; p < 11; p++) begin
            throttle_en <= (p != 6 && p != 10);
            settle();
            write_bonus((p < 9) ? BONUS_PLAN[p] : int'($urandom_range(0, 510)) - 255);
            repeat (PHASE_CELLS) send_random_cell();
        end

        settle();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && open_count == 0)
            $display("** recrystallization_cell_update: PASSED **");
        else
            $display("** recrystallization_cell_update: FAILED **");
        $finish;
    end

endmodule
